// ===== sv/gdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and constants for the graph reachability search unit.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int ADDR_NODES = 64;
  localparam int NODE_W     = 6;
  localparam int SP_W       = 7;

  typedef logic [ADDR_NODES-1:0] row_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [SP_W-1:0]       sp_t;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_Q_START,
    S_POP,
    S_ROW,
    S_CHECK,
    S_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic edge_wr;
    logic q_start;
    logic pop;
    logic row_rd;
    logic check;
    logic push;
    logic set_res;
    logic res_val;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic same;
    logic sp_zero;
    logic hit;
    logic fresh_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/graph_reachability_dfs_unit.sv =====
// ----------------------------------------------------------------------------
// graph_reachability_dfs_unit
// Directed graph store with depth-first reachability queries.
// ----------------------------------------------------------------------------
// Add-edge: reads the source row, writes it back with the dest bit; no result.
// Query: pops a node, reads and checks its row, then pushes each fresh neighbour.
// Rate is set by one adjacency RAM read per popped node, one stack push a cycle.
// One item at a time; a finished result waits in the output register.
// Reset clears the row valid bits at once: the graph is empty, no clear pass.
module graph_reachability_dfs_unit #(
  parameter int NODES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_kind_i,
  input  logic [5:0]              in_source_node_i,
  input  logic [5:0]              in_dest_node_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    out_reachable_o
);

  gdfs_pkg::cmd_t  cmd;
  gdfs_pkg::stat_t stat;

  gdfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_kind_i (in_kind_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  gdfs_dp #(
    .NODES(NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .source_node_i(in_source_node_i),
    .dest_node_i  (in_dest_node_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reachable_o  (out_reachable_o)
  );

endmodule

// ===== sv/gdfs_ram.sv =====
// ----------------------------------------------------------------------------
// gdfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gdfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for edge insertion and depth-first reachability queries.
// ----------------------------------------------------------------------------
module gdfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_kind_i,
  input  gdfs_pkg::stat_t stat_i,
  output gdfs_pkg::cmd_t  cmd_o
);

  gdfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdfs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      gdfs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_kind_i == gdfs_pkg::KIND_EDGE) ? gdfs_pkg::S_EDGE_RD
                                                       : gdfs_pkg::S_Q_START;
        end
      end
      gdfs_pkg::S_EDGE_RD: begin
        state_d = stat_i.live ? gdfs_pkg::S_EDGE_WR : gdfs_pkg::S_IDLE;
      end
      gdfs_pkg::S_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d = gdfs_pkg::S_IDLE;
      end
      gdfs_pkg::S_Q_START: begin
        if (stat_i.same) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_val = 1'b1;
          state_d = gdfs_pkg::S_DONE;
        end else if (!stat_i.live) begin
          cmd_o.set_res = 1'b1;
          state_d = gdfs_pkg::S_DONE;
        end else begin
          cmd_o.q_start = 1'b1;
          state_d = gdfs_pkg::S_POP;
        end
      end
      gdfs_pkg::S_POP: begin
        if (stat_i.sp_zero) begin
          cmd_o.set_res = 1'b1;
          state_d = gdfs_pkg::S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = gdfs_pkg::S_ROW;
        end
      end
      gdfs_pkg::S_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d = gdfs_pkg::S_CHECK;
      end
      gdfs_pkg::S_CHECK: begin
        if (stat_i.hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_val = 1'b1;
          state_d = gdfs_pkg::S_DONE;
        end else begin
          cmd_o.check = 1'b1;
          state_d = gdfs_pkg::S_PUSH;
        end
      end
      gdfs_pkg::S_PUSH: begin
        if (stat_i.fresh_zero) begin
          state_d = gdfs_pkg::S_POP;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      gdfs_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = gdfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gdfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gdfs_dp.sv =====
// ----------------------------------------------------------------------------
// gdfs_dp
// Datapath: adjacency RAM with row valid bits, search stack RAM, visited
// set, push scan and result register.
// ----------------------------------------------------------------------------
module gdfs_dp #(
  parameter int NODES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gdfs_pkg::cmd_t  cmd_i,
  output gdfs_pkg::stat_t stat_o,
  input  gdfs_pkg::node_t source_node_i,
  input  gdfs_pkg::node_t dest_node_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            reachable_o
);

  localparam gdfs_pkg::row_t LIVE = (NODES >= gdfs_pkg::ADDR_NODES) ? '1 :
      gdfs_pkg::row_t'((gdfs_pkg::row_t'(1) << NODES) - gdfs_pkg::row_t'(1));

  gdfs_pkg::node_t src_q, dst_q, node_q;
  gdfs_pkg::row_t  fresh_q, visited_q, row_vld_q;
  gdfs_pkg::sp_t   sp_q;
  logic            res_q, out_valid_q, out_reach_q;

  gdfs_pkg::row_t  adj_rdata, adj_wdata, row_eff, fresh_c, low_bit, dbit;
  gdfs_pkg::node_t adj_raddr, stk_rdata, stk_waddr, stk_wdata, low_idx, row_sel;
  logic            stk_we;
  gdfs_pkg::sp_t   sp_dec;

  assign dbit    = gdfs_pkg::row_t'(1) << dst_q;
  assign sp_dec  = sp_q - gdfs_pkg::sp_t'(1);
  assign row_sel = cmd_i.edge_wr ? src_q : node_q;
  assign row_eff = row_vld_q[row_sel] ? adj_rdata : '0;

  assign adj_raddr = cmd_i.row_rd ? stk_rdata : src_q;
  assign adj_wdata = row_eff | dbit;
  assign fresh_c   = row_eff & LIVE & ~visited_q;
  assign low_bit   = fresh_q & (~fresh_q + gdfs_pkg::row_t'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < gdfs_pkg::ADDR_NODES; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | gdfs_pkg::node_t'(i);
      end
    end
  end

  assign stk_we    = cmd_i.q_start | cmd_i.push;
  assign stk_waddr = cmd_i.q_start ? '0 : sp_q[gdfs_pkg::NODE_W-1:0];
  assign stk_wdata = cmd_i.q_start ? src_q : low_idx;

  gdfs_ram #(
    .WIDTH(gdfs_pkg::ADDR_NODES),
    .DEPTH(gdfs_pkg::ADDR_NODES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.edge_wr),
    .waddr_i(src_q),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  gdfs_ram #(
    .WIDTH(gdfs_pkg::NODE_W),
    .DEPTH(gdfs_pkg::ADDR_NODES)
  ) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(sp_dec[gdfs_pkg::NODE_W-1:0]),
    .rdata_o(stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      visited_q   <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.edge_wr) begin
        row_vld_q[src_q] <= 1'b1;
      end
      if (cmd_i.q_start) begin
        visited_q <= gdfs_pkg::row_t'(1) << src_q;
        sp_q      <= gdfs_pkg::sp_t'(1);
      end else if (cmd_i.pop) begin
        sp_q <= sp_dec;
      end else if (cmd_i.push) begin
        visited_q <= visited_q | low_bit;
        sp_q      <= sp_q + gdfs_pkg::sp_t'(1);
      end else if (cmd_i.set_res) begin
        sp_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q <= source_node_i;
      dst_q <= dest_node_i;
    end
    if (cmd_i.row_rd) begin
      node_q <= stk_rdata;
    end
    if (cmd_i.check) begin
      fresh_q <= fresh_c;
    end else if (cmd_i.push) begin
      fresh_q <= fresh_q & (fresh_q - gdfs_pkg::row_t'(1));
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_val;
    end
    if (cmd_i.emit) begin
      out_reach_q <= res_q;
    end
  end

  assign stat_o.live       = LIVE[src_q] & LIVE[dst_q];
  assign stat_o.same       = (src_q == dst_q);
  assign stat_o.sp_zero    = (sp_q == '0);
  assign stat_o.hit        = |(fresh_c & dbit);
  assign stat_o.fresh_zero = (fresh_q == '0);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign reachable_o = out_reach_q;

endmodule

// ===== dv/graph_reachability_dfs_unit_tb.sv =====
// ----------------------------------------------------------------------------
// graph_reachability_dfs_unit_tb
// Feeds add-edge and reachability-query beats into the search unit and keeps
// a private copy of the adjacency matrix. Every query is answered by a
// transitive-closure walk over that copy and compared with the unit's result.
// A short directed part is followed by random beats: forward edges across all
// nodes and edges in any direction inside four groups of sixteen nodes, with
// random idling, long output hold-offs and full drains in between.
// ----------------------------------------------------------------------------
module graph_reachability_dfs_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT  = 38;
  localparam int HOLD_LEN  = 400;
  localparam int WDOG_MAX  = 5000;
  localparam int TAIL_CYC  = 40;

  typedef struct {
    logic            kind;
    gdfs_pkg::node_t src;
    gdfs_pkg::node_t dst;
  } beat_t;

  typedef struct {
    gdfs_pkg::node_t src;
    gdfs_pkg::node_t dst;
    logic            reach;
  } answer_t;

  logic            clk_i            = 1'b0;
  logic            rst_ni           = 1'b0;
  logic            in_valid_i       = 1'b0;
  logic            in_kind_i        = gdfs_pkg::KIND_EDGE;
  gdfs_pkg::node_t in_source_node_i = '0;
  gdfs_pkg::node_t in_dest_node_i   = '0;
  logic            out_stall_i      = 1'b0;
  logic            in_stall_o;
  logic            out_valid_o;
  logic            out_reachable_o;

  beat_t          pending_beats[$];
  answer_t        answers_due[$];
  gdfs_pkg::row_t graph_rows[gdfs_pkg::ADDR_NODES];
  beat_t          next_beat;
  answer_t        got_answer;
  int             beats_in;
  int             answers_out;
  int             hold_left;
  int             quiet_cycles;
  int             errors;

  graph_reachability_dfs_unit #(.NODES(64)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_source_node_i(in_source_node_i),
    .in_dest_node_i  (in_dest_node_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_reachable_o (out_reachable_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic path_exists(gdfs_pkg::node_t s, gdfs_pkg::node_t d);
    gdfs_pkg::row_t seen;
    gdfs_pkg::row_t grown;
    if (s == d) return 1'b1;
    seen = gdfs_pkg::row_t'(1) << s;
    forever begin
      grown = seen;
      for (int n = 0; n < gdfs_pkg::ADDR_NODES; n++) begin
        if (seen[n]) grown |= graph_rows[n];
      end
      if (grown == seen) break;
      seen = grown;
    end
    return seen[d];
  endfunction

  function automatic logic calm_window();
    return beats_in >= 1000 && beats_in < 1300;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      in_kind_i        <= gdfs_pkg::KIND_EDGE;
      in_source_node_i <= '0;
      in_dest_node_i   <= '0;
      beats_in         <= 0;
      for (int n = 0; n < gdfs_pkg::ADDR_NODES; n++) graph_rows[n] = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        beats_in <= beats_in + 1;
        if (in_kind_i == gdfs_pkg::KIND_EDGE) begin
          graph_rows[in_source_node_i][in_dest_node_i] = 1'b1;
        end else begin
          answers_due.insert(answers_due.size(),
                             '{in_source_node_i, in_dest_node_i,
                               path_exists(in_source_node_i, in_dest_node_i)});
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() != 0 &&
            (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
          next_beat = pending_beats.pop_front();
          in_valid_i       <= 1'b1;
          in_kind_i        <= next_beat.kind;
          in_source_node_i <= next_beat.src;
          in_dest_node_i   <= next_beat.dst;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      answers_out <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        answers_out <= answers_out + 1;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual reachable=%0b",
                   $time, out_reachable_o);
          errors++;
        end else begin
          got_answer = answers_due.pop_front();
          if (out_reachable_o !== got_answer.reach) begin
            $display("%0t: query %0d->%0d reachable expected %0b actual %0b",
                     $time, got_answer.src, got_answer.dst, got_answer.reach,
                     out_reachable_o);
            errors++;
          end
        end
      end
      if (out_valid_o && !out_stall_i && (answers_out == 30 || answers_out == 600))
        hold_left <= HOLD_LEN;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
      out_stall_i <= (hold_left != 0) ||
                     (!calm_window() && $urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WDOG_MAX);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_beat(logic kind, int s, int d);
    pending_beats.insert(pending_beats.size(),
                         '{kind, gdfs_pkg::node_t'(s), gdfs_pkg::node_t'(d)});
  endtask

  task automatic add_random_beats(int count, int edge_pct);
    int a;
    int b;
    int t;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(63);
      b = $urandom_range(63);
      if ($urandom_range(99) < edge_pct) begin
        // forward edges across the whole range, any direction inside a group
        if ($urandom_range(99) < 70) begin
          if (a > b) begin
            t = a;
            a = b;
            b = t;
          end
        end else begin
          b = (a & 48) | (b & 15);
        end
        add_beat(gdfs_pkg::KIND_EDGE, a, b);
      end else begin
        if ($urandom_range(99) < 10) b = a;
        add_beat(gdfs_pkg::KIND_QUERY, a, b);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || answers_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    errors       = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_beat(gdfs_pkg::KIND_QUERY, 0, 0);      // self query on empty graph
    add_beat(gdfs_pkg::KIND_QUERY, 63, 63);
    add_beat(gdfs_pkg::KIND_QUERY, 0, 63);
    add_beat(gdfs_pkg::KIND_EDGE, 0, 63);
    add_beat(gdfs_pkg::KIND_QUERY, 0, 63);
    add_beat(gdfs_pkg::KIND_QUERY, 63, 0);
    add_beat(gdfs_pkg::KIND_EDGE, 0, 63);      // repeated edge
    add_beat(gdfs_pkg::KIND_QUERY, 0, 63);
    add_beat(gdfs_pkg::KIND_EDGE, 63, 63);     // self loop
    add_beat(gdfs_pkg::KIND_QUERY, 63, 63);
    add_beat(gdfs_pkg::KIND_EDGE, 63, 0);
    add_beat(gdfs_pkg::KIND_QUERY, 63, 0);
    add_beat(gdfs_pkg::KIND_EDGE, 10, 20);
    add_beat(gdfs_pkg::KIND_EDGE, 20, 42);
    add_beat(gdfs_pkg::KIND_EDGE, 42, 21);
    add_beat(gdfs_pkg::KIND_QUERY, 10, 21);
    add_beat(gdfs_pkg::KIND_QUERY, 21, 10);
    add_beat(gdfs_pkg::KIND_QUERY, 5, 6);
    add_beat(gdfs_pkg::KIND_EDGE, 42, 0);
    add_beat(gdfs_pkg::KIND_QUERY, 10, 63);
    wait_drained();

    add_random_beats(950, 30);
    wait_drained();
    add_random_beats(950, 15);
    wait_drained();

    repeat (TAIL_CYC) @(posedge clk_i);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gdfs_pkg.sv
sv/gdfs_ram.sv
sv/gdfs_ctrl.sv
sv/gdfs_dp.sv
sv/graph_reachability_dfs_unit.sv
dv/graph_reachability_dfs_unit_tb.sv
